>>> rtl/bnsp_pkg.sv
// ----------------------------------------------------------------------------
// bnsp_pkg
// Types and constants shared by the blocked-node shortest path block.
// ----------------------------------------------------------------------------
package bnsp_pkg;

    localparam int          DIST_W    = 20;
    localparam int          WEIGHT_W  = 8;
    localparam int          FIELD_W   = 5;
    localparam int          MASK_W    = 32;
    localparam logic [19:0] UNREACHED = 20'd1000000;

    // input word kinds
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // configuration register indexes
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    typedef logic [2:0] t_op;

    // cell operations
    localparam t_op OP_IDLE  = 3'd0;
    localparam t_op OP_CLEAR = 3'd1;
    localparam t_op OP_ERD   = 3'd2;
    localparam t_op OP_EWR   = 3'd3;
    localparam t_op OP_INIT  = 3'd4;
    localparam t_op OP_LOAD  = 3'd5;
    localparam t_op OP_SCAN  = 3'd6;

    typedef struct packed {
        t_op                 op;
        logic [FIELD_W-1:0]  src;
        logic [FIELD_W-1:0]  node_a;
        logic [FIELD_W-1:0]  node_b;
        logic [WEIGHT_W-1:0] weight;
    } t_cell_ctrl;

endpackage

>>> rtl/bnsp_ram.sv
// ----------------------------------------------------------------------------
// bnsp_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bnsp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bnsp_cell.sv
// ----------------------------------------------------------------------------
// bnsp_cell
// One node of the graph: its incoming edge row, its distance, and one stage
// of the token ring that carries distances from cell to cell.
// ----------------------------------------------------------------------------
module bnsp_cell import bnsp_pkg::*; #(
    parameter int NODES = 32,
    parameter int IDX   = 0,
    localparam int AW   = $clog2(NODES)
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [AW-1:0]     i_clr_addr,
    input  logic              i_blocked,
    input  logic [DIST_W-1:0] i_prev_tok,
    input  logic [AW-1:0]     i_prev_node,
    output logic [DIST_W-1:0] o_tok,
    output logic [AW-1:0]     o_node,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_chg
);

    localparam logic [AW-1:0] MY = AW'(IDX);

    logic [DIST_W-1:0]   r_dist;
    logic [DIST_W-1:0]   r_tok;
    logic [AW-1:0]       r_node;
    logic                r_chg;

    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;
    logic                w_we;
    logic [WEIGHT_W:0]   w_wdata;
    logic [WEIGHT_W:0]   w_rdata;
    logic [AW-1:0]       w_edge_addr;
    logic                w_is_end;
    logic [DIST_W:0]     w_sum;
    logic                w_relax;

    // row entry u holds the edge u -> this node
    assign w_edge_addr = (int'(i_ctrl.node_b) == IDX) ? AW'(i_ctrl.node_a)
                                                       : AW'(i_ctrl.node_b);
    assign w_is_end    = (int'(i_ctrl.node_a) == IDX) || (int'(i_ctrl.node_b) == IDX);

    always_comb begin
        w_raddr = MY;
        w_we    = 1'b0;
        w_waddr = w_edge_addr;
        w_wdata = {1'b1, i_ctrl.weight};
        unique case (i_ctrl.op)
            OP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = i_clr_addr;
                w_wdata = '0;
            end
            OP_ERD: begin
                w_raddr = w_edge_addr;
            end
            OP_EWR: begin
                w_raddr = w_edge_addr;
                // keep the lighter of parallel edges
                w_we    = w_is_end && (!w_rdata[WEIGHT_W] ||
                                       (i_ctrl.weight < w_rdata[WEIGHT_W-1:0]));
            end
            OP_SCAN: begin
                w_raddr = i_prev_node;
            end
            default: begin
            end
        endcase
    end

    bnsp_ram #(
        .WIDTH (WEIGHT_W + 1),
        .DEPTH (NODES)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_sum   = {1'b0, r_tok} + (DIST_W+1)'(w_rdata[WEIGHT_W-1:0]);
    assign w_relax = (r_tok < UNREACHED) && w_rdata[WEIGHT_W] && !i_blocked &&
                     (w_sum < {1'b0, r_dist});

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_INIT: begin
                r_dist <= (int'(i_ctrl.src) == IDX) ? '0 : UNREACHED;
            end
            OP_LOAD: begin
                r_tok  <= r_dist;
                r_node <= MY;
                r_chg  <= 1'b0;
            end
            OP_SCAN: begin
                if (w_relax) begin
                    r_dist <= w_sum[DIST_W-1:0];
                    r_chg  <= 1'b1;
                end
                // advance the ring
                r_tok  <= i_prev_tok;
                r_node <= i_prev_node;
            end
            default: begin
            end
        endcase
    end

    assign o_tok  = r_tok;
    assign o_node = r_node;
    assign o_dist = r_dist;
    assign o_chg  = r_chg;

endmodule

>>> rtl/blocked_node_shortest_path.sv
// ----------------------------------------------------------------------------
// blocked_node_shortest_path
// Shortest distance between two nodes of a stored graph, avoiding blocked
// nodes, by rounds of relaxation over a ring of node cells.
// ----------------------------------------------------------------------------
//  channel  direction  fields (lowest bit up)
//  s        in         tdata: node_a, node_b, weight, blocked_mask; tuser: mode
//  m        out        tdata: distance; tuser: reachable
//  cfg      in         index 0 source_node, 1 target_node
//
//  Edge add: a row read, then a row write. Graph clear: a pass over all edge rows.
//  Query: an init step, then R rounds of the distance ring, R at most
//  NODES - 1; each round shifts every distance once around all cells.
//  Reset runs a clearing pass over all of the edge rows; no word is
//  accepted then. A result waiting on m holds the block before it returns idle.
// ----------------------------------------------------------------------------
module blocked_node_shortest_path import bnsp_pkg::*; #(
    parameter int NODES = 32,
    localparam int AW   = $clog2(NODES)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // node_a, node_b, weight, blocked_mask
    input  logic [1:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // distance
    output logic [0:0]  o_m_tuser,   // reachable
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [4:0]  i_cfg_wdata
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ERD   = 4'd2;
    localparam logic [3:0] S_EWR   = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_CHECK = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    logic [3:0]          r_state;
    logic [AW-1:0]       r_cnt;
    logic [AW-1:0]       r_round;
    logic [4:0]          r_src;
    logic [4:0]          r_tgt;
    logic [4:0]          r_node_a;
    logic [4:0]          r_node_b;
    logic [7:0]          r_weight;
    logic [MASK_W-1:0]   r_mask;
    logic                r_oor;
    logic                r_out_valid;
    logic [DIST_W-1:0]   r_out_dist;
    logic                r_out_ok;

    logic                w_accept;
    logic                w_out_free;
    logic                w_any_chg;
    logic                w_src_oor;
    logic                w_a_ok;
    logic                w_b_ok;
    logic [DIST_W-1:0]   w_res_dist;
    t_cell_ctrl          w_ctrl;

    logic [DIST_W-1:0]   w_tok  [NODES];
    logic [AW-1:0]       w_node [NODES];
    logic [DIST_W-1:0]   w_dist [NODES];
    logic [NODES-1:0]    w_chg;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_any_chg  = |w_chg;
    assign w_src_oor  = (int'(r_src) >= NODES) || (int'(r_tgt) >= NODES);
    assign w_a_ok     = int'(i_s_tdata[4:0]) < NODES;
    assign w_b_ok     = int'(i_s_tdata[9:5]) < NODES;
    assign w_res_dist = r_oor ? UNREACHED : w_dist[AW'(r_tgt)];

    always_comb begin
        w_ctrl.src    = r_src;
        w_ctrl.node_a = r_node_a;
        w_ctrl.node_b = r_node_b;
        w_ctrl.weight = r_weight;
        unique case (r_state)
            S_CLEAR: w_ctrl.op = OP_CLEAR;
            S_ERD:   w_ctrl.op = OP_ERD;
            S_EWR:   w_ctrl.op = OP_EWR;
            S_INIT:  w_ctrl.op = OP_INIT;
            S_LOAD:  w_ctrl.op = OP_LOAD;
            S_SCAN:  w_ctrl.op = OP_SCAN;
            default: w_ctrl.op = OP_IDLE;
        endcase
    end

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        localparam int PREV = (g == 0) ? NODES - 1 : g - 1;
        logic w_blocked;
        if (g < MASK_W) begin : g_mask
            assign w_blocked = r_mask[g];
        end else begin : g_free
            assign w_blocked = 1'b0;
        end
        bnsp_cell #(
            .NODES (NODES),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_clr_addr  (r_cnt),
            .i_blocked   (w_blocked),
            .i_prev_tok  (w_tok[PREV]),
            .i_prev_node (w_node[PREV]),
            .o_tok       (w_tok[g]),
            .o_node      (w_node[g]),
            .o_dist      (w_dist[g]),
            .o_chg       (w_chg[g])
        );
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= 5'd0;
            r_tgt <= 5'd31;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SOURCE: r_src <= i_cfg_wdata;
                REG_TARGET: r_tgt <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // capture the word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_node_a <= i_s_tdata[4:0];
            r_node_b <= i_s_tdata[9:5];
            r_weight <= i_s_tdata[17:10];
            r_mask   <= i_s_tdata[49:18];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_round <= '0;
            r_oor   <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt <= '0;
                        unique case (i_s_tuser)
                            MODE_ADD:   r_state <= (w_a_ok && w_b_ok) ? S_ERD : S_IDLE;
                            MODE_CLEAR: r_state <= S_CLEAR;
                            MODE_QUERY: begin
                                r_oor   <= w_src_oor;
                                r_state <= w_src_oor ? S_DONE : S_INIT;
                            end
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ERD:   r_state <= S_EWR;
                S_EWR:   r_state <= S_IDLE;
                S_INIT: begin
                    r_round <= AW'(1);
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_any_chg || (r_round == LAST)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_round <= r_round + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_dist <= w_res_dist;
            r_out_ok   <= (w_res_dist != UNREACHED);
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {4'b0, r_out_dist};
    assign o_m_tuser[0] = r_out_ok;

    a_query_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tuser == MODE_QUERY) |=> !o_s_tready)
        else $error("input taken during a query");

    a_reach_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (o_m_tdata[19:0] != UNREACHED)))
        else $error("reachable flag disagrees with distance");

    a_check_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(r_state) == S_SCAN)
        else $error("round check without a scan");

endmodule

>>> dv/blocked_node_shortest_path_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blocked_node_shortest_path_tb
// Loads random and hand-built graphs, runs queries under blocked-node masks
// and checks each distance word against a relaxation predictor in the bench.
// ----------------------------------------------------------------------------
module blocked_node_shortest_path_tb import bnsp_pkg::*;;

    localparam int N        = 32;
    localparam int N_RAND   = 500;
    localparam int CYC_MAX  = 3000000;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  node_a;
        logic [4:0]  node_b;
        logic [7:0]  weight;
        logic [31:0] blocked;
        logic        has_exp;
        logic [19:0] exp_dist;
        logic        exp_reach;
    } t_row;

    typedef struct packed {
        logic [19:0] distance;
        logic        reach;
    } t_dist;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [4:0]  i_cfg_wdata = '0;

    blocked_node_shortest_path dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic        link_on [N*N];
    logic [7:0]  link_len [N*N];
    logic [4:0]  src_node, dst_node;
    t_dist       dist_q[$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_off = 1'b0;

    function automatic t_dist solve_path(logic [31:0] blocked);
        logic [20:0] d [N];
        logic [20:0] nd;
        bit          moved;
        t_dist       r;
        for (int u = 0; u < N; u++) d[u] = {1'b0, UNREACHED};
        d[src_node] = '0;
        for (int k = 1; k < N; k++) begin
            moved = 0;
            for (int u = 0; u < N; u++) begin
                if (d[u] >= UNREACHED) continue;
                for (int v = 0; v < N; v++) begin
                    if (!link_on[u*N+v] || blocked[v]) continue;
                    nd = d[u] + link_len[u*N+v];
                    if (nd < d[v]) begin
                        d[v] = nd;
                        moved = 1;
                    end
                end
            end
            if (!moved) break;
        end
        r.distance = d[dst_node][19:0];
        r.reach    = d[dst_node] < UNREACHED;
        return r;
    endfunction

    function automatic void note_link(int a, int b, logic [7:0] w);
        if (!link_on[a*N+b] || w < link_len[a*N+b]) begin
            link_on[a*N+b]  = 1'b1;
            link_len[a*N+b] = w;
        end
    endfunction

    // hold valid across back-to-back words, drop it only for an idle gap
    task automatic send_word(t_row r);
        t_dist e;
        int    gap;
        gap = $urandom_range(0, 16);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.mode;
        i_s_tdata  <= {6'b0, r.blocked, r.weight, r.node_b, r.node_a};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        case (r.mode)
            MODE_ADD: begin
                note_link(r.node_a, r.node_b, r.weight);
                note_link(r.node_b, r.node_a, r.weight);
            end
            MODE_CLEAR: for (int i = 0; i < N*N; i++) link_on[i] = 1'b0;
            MODE_QUERY: begin
                e = solve_path(r.blocked);
                if (r.has_exp && (e.distance != r.exp_dist || e.reach != r.exp_reach)) begin
                    $error("table row disagrees: distance exp %0d pred %0d",
                           r.exp_dist, e.distance);
                    errors++;
                end
                dist_q.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (3 + (N - 1) * (N + 2) + 8) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [0:0] idx, logic [4:0] val);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SOURCE) src_node = val; else dst_node = val;
    endtask

    function automatic t_row mk(logic [1:0] m, int a, int b, int w,
                                logic [31:0] blk);
        t_row r;
        r = '0;
        r.mode = m; r.node_a = 5'(a); r.node_b = 5'(b); r.weight = 8'(w);
        r.blocked = blk;
        return r;
    endfunction

    function automatic t_row mkq(logic [31:0] blk, bit chk, int d, bit rch);
        t_row r;
        r = mk(MODE_QUERY, 0, 0, 0, blk);
        r.has_exp = chk; r.exp_dist = 20'(d); r.exp_reach = rch;
        return r;
    endfunction

    // result check; the receiver below gives random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        t_dist e;
        cycles <= cycles + 1;
        if (cycles > CYC_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (dist_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = dist_q.pop_front();
                if (o_m_tdata[19:0] !== e.distance) begin
                    $error("distance exp %0d got %0d", e.distance, o_m_tdata[19:0]);
                    errors++;
                end
                if (o_m_tdata[23:20] !== 4'd0) begin
                    $error("pad exp 0 got %0h", o_m_tdata[23:20]);
                    errors++;
                end
                if (o_m_tuser[0] !== e.reach) begin
                    $error("reachable exp %0d got %0d", e.reach, o_m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) i_m_tready <= 1'b0;
            else if (gap > 0) begin
                i_m_tready <= 1'b0;
                gap--;
            end else begin
                i_m_tready <= 1'b1;
                if (o_m_tvalid && i_m_tready)
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
        end
    end

    t_row tbl[$];

    initial begin
        t_row r;
        int   k, hub;
        for (int i = 0; i < N*N; i++) link_on[i] = 1'b0;
        src_node = 5'd0;
        dst_node = 5'd31;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty graph, chain 0..31, extremes, blocking, modes
        tbl.push_back(mkq(32'h0, 1, UNREACHED, 0));
        tbl.push_back(mk(MODE_NONE, 1, 2, 3, 32'hFFFF_FFFF));
        tbl.push_back(mk(MODE_ADD, 0, 31, 255, 0));
        tbl.push_back(mk(MODE_ADD, 31, 0, 200, 0));
        tbl.push_back(mkq(32'h0, 1, 200, 1));
        tbl.push_back(mkq(32'h8000_0000, 1, UNREACHED, 0));
        tbl.push_back(mkq(32'h7FFF_FFFF, 1, 200, 1));
        tbl.push_back(mk(MODE_ADD, 5, 5, 0, 0));
        tbl.push_back(mk(MODE_ADD, 0, 1, 0, 0));
        tbl.push_back(mk(MODE_ADD, 1, 31, 0, 0));
        tbl.push_back(mkq(32'h0, 1, 0, 1));
        tbl.push_back(mkq(32'h2, 1, 200, 1));
        tbl.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));
        tbl.push_back(mkq(32'h0, 1, UNREACHED, 0));
        for (int i = 0; i < 31; i++) tbl.push_back(mk(MODE_ADD, i, i + 1, 255, 0));
        tbl.push_back(mkq(32'h0, 1, 31 * 255, 1));
        tbl.push_back(mkq(32'hFFFF_FFFF, 0, 0, 0));
        while (tbl.size() != 0) send_word(tbl.pop_front());
        drain();

        // source blocked and target equal to source
        set_reg(REG_SOURCE, 5'd31);
        set_reg(REG_TARGET, 5'd31);
        send_word(mkq(32'hFFFF_FFFF, 1, 0, 1));
        drain();
        set_reg(REG_TARGET, 5'd0);
        send_word(mkq(32'h8000_0000, 1, 31 * 255, 1));
        send_word(mkq(32'h0000_0100, 1, UNREACHED, 0));

        // long receiver hold-off while the sender keeps offering queries
        hold_off = 1'b1;
        fork
            begin repeat (3000) @(posedge i_clk); hold_off = 1'b0; end
            for (int i = 0; i < 4; i++) send_word(mkq($urandom, 0, 0, 0));
        join
        drain();

        k = 0;
        while (k < N_RAND) begin
            if (k % 70 == 0) begin
                drain();
                set_reg(REG_SOURCE, $urandom_range(0, 3) == 0 ? 5'd0 : 5'($urandom));
                set_reg(REG_TARGET, $urandom_range(0, 3) == 0 ? 5'd31 : 5'($urandom));
                send_word(mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom));
                k++;
            end
            hub = $urandom_range(0, 31);
            case ($urandom_range(0, 19))
                0:  r = mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom);
                1,2,3,4,5,6,7,8,9,10,11: begin
                    r = mk(MODE_ADD, $urandom, $urandom, $urandom, $urandom);
                    if ($urandom_range(0, 1)) r.node_a = 5'(hub);
                    if ($urandom_range(0, 4) == 0) r.weight = 8'($urandom_range(0, 3));
                end
                default: begin
                    r = mkq($urandom, 0, 0, 0);
                    if ($urandom_range(0, 1)) r.blocked = r.blocked & $urandom & $urandom;
                    if ($urandom_range(0, 4) == 0) r.blocked = 32'h0;
                end
            endcase
            send_word(r);
            if (r.mode != MODE_NONE) k++;
            if (k == N_RAND / 2) drain();
        end

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
